>>> rtl/svm_iod_pkg.sv
// Package for the SVM implicit-operand decoder: beat types, status codes,
// exit codes, opcode constants and queue sizing. No dependencies.
package svm_iod_pkg;

  localparam int MAX_LENGTH = 15;
  localparam int CNT_W      = $clog2(MAX_LENGTH + 2);

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [11:0] EXIT_VMRUN   = 12'h080;
  localparam logic [11:0] EXIT_VMLOAD  = 12'h082;
  localparam logic [11:0] EXIT_VMSAVE  = 12'h083;
  localparam logic [11:0] EXIT_INVLPGA = 12'h07A;

  localparam logic [7:0] OPC_VMRUN   = 8'hD8;
  localparam logic [7:0] OPC_INVLPGA = 8'hDF;
  localparam logic [7:0] OPC_ADJ     = 8'h58;
  localparam logic [7:0] ESC_0F      = 8'h0F;
  localparam logic [7:0] ESC_01      = 8'h01;
  localparam logic [7:0] PFX_ADDR    = 8'h67;
  localparam logic [7:0] PFX_OPSZ    = 8'h66;
  localparam logic [7:0] PFX_REPNE   = 8'hF2;
  localparam logic [7:0] PFX_REP     = 8'hF3;
  localparam logic [7:0] PFX_ES      = 8'h26;
  localparam logic [7:0] PFX_CS      = 8'h2E;
  localparam logic [7:0] PFX_SS      = 8'h36;
  localparam logic [7:0] PFX_DS      = 8'h3E;
  localparam logic [7:0] PFX_FS      = 8'h64;
  localparam logic [7:0] PFX_GS      = 8'h65;
  localparam logic [7:0] REX_LO      = 8'h40;
  localparam logic [7:0] REX_HI      = 8'h4F;

  localparam logic [6:0] ASZ_NONE = 7'd0;
  localparam logic [6:0] ASZ_16   = 7'd16;
  localparam logic [6:0] ASZ_32   = 7'd32;
  localparam logic [6:0] ASZ_64   = 7'd64;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_RETRY       = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]  instr_byte;
    logic        last_byte;
    logic [11:0] exit_code;
    logic        long_code;
    logic        default_32;
    logic [63:0] accumulator;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] operand;
    logic [6:0]  address_size;
  } out_beat_t;

  // Classified instruction handed from front to back
  typedef struct packed {
    status_t     status;
    logic        override_seen;
    logic        long_code;
    logic        default_32;
    logic [63:0] accumulator;
  } desc_t;

endpackage

>>> rtl/svm_iod_front.sv
// Front end: takes instruction bytes, tracks window, count and prefix flags,
// and classifies the instruction on its last byte. Uses svm_iod_pkg.
module svm_iod_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  svm_iod_pkg::in_beat_t in_data,
  input  logic                  q_full,
  output logic                  q_push,
  output svm_iod_pkg::desc_t    q_desc
);
  import svm_iod_pkg::*;

  logic [7:0]       win0_r, win0_nxt;
  logic [7:0]       win1_r, win1_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovr_r, ovr_nxt;
  logic             rex_r, rex_nxt;
  logic             bad_r, bad_nxt;

  logic             accept;
  logic [7:0]       expected;
  logic             code_known;
  logic             len_bad;
  logic             is_ovr, is_plain, is_rex;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    is_ovr   = (win0_r == PFX_ADDR);
    is_plain = (win0_r == PFX_OPSZ) || (win0_r == PFX_REPNE) || (win0_r == PFX_REP) ||
               (win0_r == PFX_ES) || (win0_r == PFX_CS) || (win0_r == PFX_SS) ||
               (win0_r == PFX_DS) || (win0_r == PFX_FS) || (win0_r == PFX_GS);
    is_rex   = (win0_r >= REX_LO) && (win0_r <= REX_HI);
  end

  always_comb begin
    win0_nxt  = win0_r;
    win1_nxt  = win1_r;
    count_nxt = count_r;
    ovr_nxt   = ovr_r;
    rex_nxt   = rex_r;
    bad_nxt   = bad_r;
    if (accept && in_data.last_byte) begin
      win0_nxt  = '0;
      win1_nxt  = '0;
      count_nxt = '0;
      ovr_nxt   = 1'b0;
      rex_nxt   = 1'b0;
      bad_nxt   = 1'b0;
    end else if (accept) begin
      // oldest window byte is a prefix once two more bytes follow it
      if (count_r >= CNT_W'(2)) begin
        if (is_ovr) begin
          ovr_nxt = 1'b1;
        end else if (is_plain) begin
          ovr_nxt = ovr_r;
        end else if (is_rex) begin
          rex_nxt = 1'b1;
        end else begin
          bad_nxt = 1'b1;
        end
      end
      win0_nxt = win1_r;
      win1_nxt = in_data.instr_byte;
      if (count_r < CNT_W'(MAX_LENGTH + 1)) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_r  <= '0;
      win1_r  <= '0;
      count_r <= '0;
      ovr_r   <= 1'b0;
      rex_r   <= 1'b0;
      bad_r   <= 1'b0;
    end else begin
      win0_r  <= win0_nxt;
      win1_r  <= win1_nxt;
      count_r <= count_nxt;
      ovr_r   <= ovr_nxt;
      rex_r   <= rex_nxt;
      bad_r   <= bad_nxt;
    end
  end

  always_comb begin
    code_known = 1'b1;
    expected   = '0;
    unique case (in_data.exit_code)
      EXIT_VMRUN:   expected = OPC_VMRUN;
      EXIT_VMLOAD:  expected = EXIT_VMLOAD[7:0] + OPC_ADJ;
      EXIT_VMSAVE:  expected = EXIT_VMSAVE[7:0] + OPC_ADJ;
      EXIT_INVLPGA: expected = OPC_INVLPGA;
      default:      code_known = 1'b0;
    endcase
  end

  // length = count + 1 must lie in 3..MAX_LENGTH
  assign len_bad = (count_r < CNT_W'(2)) || (count_r > CNT_W'(MAX_LENGTH - 1));

  always_comb begin
    q_desc.override_seen = ovr_r;
    q_desc.long_code     = in_data.long_code;
    q_desc.default_32    = in_data.default_32;
    q_desc.accumulator   = in_data.accumulator;
    priority if (len_bad || !code_known) begin
      q_desc.status = ST_UNSUPPORTED;
    end else if ((win0_r != ESC_0F) || (win1_r != ESC_01) ||
                 (in_data.instr_byte != expected)) begin
      q_desc.status = ST_RETRY;
    end else if (bad_r || (rex_r && !in_data.long_code)) begin
      q_desc.status = ST_RETRY;
    end else begin
      q_desc.status = ST_OK;
    end
  end

  assign q_push = accept && in_data.last_byte;

endmodule

>>> rtl/svm_iod_queue.sv
// Short queue of classified instructions between front and back.
// Uses svm_iod_pkg for the descriptor type and depth.
module svm_iod_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  svm_iod_pkg::desc_t push_desc,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output svm_iod_pkg::desc_t pop_desc
);
  import svm_iod_pkg::*;

  desc_t            slot_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0]  fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign full     = (fill_r == Q_CW'(Q_DEPTH));
  assign empty    = (fill_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_desc = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_AW'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + Q_CW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

>>> rtl/svm_iod_back.sv
// Back end: picks the effective address size, masks rAX and holds the
// result beat in an output register. Uses svm_iod_pkg.
module svm_iod_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  svm_iod_pkg::desc_t     q_desc,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output svm_iod_pkg::out_beat_t out_data
);
  import svm_iod_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_beat_t out_r;
  out_beat_t res;

  assign q_pop = !q_empty && (!out_valid_r || out_ready);

  always_comb begin
    res.status       = q_desc.status;
    res.address_size = ASZ_NONE;
    res.operand      = '0;
    if (q_desc.status == ST_OK) begin
      if (q_desc.long_code) begin
        res.address_size = q_desc.override_seen ? ASZ_32 : ASZ_64;
      end else begin
        res.address_size = (q_desc.default_32 != q_desc.override_seen) ? ASZ_32 : ASZ_16;
      end
      unique case (res.address_size)
        ASZ_64:  res.operand = q_desc.accumulator;
        ASZ_32:  res.operand = {32'd0, q_desc.accumulator[31:0]};
        default: res.operand = {48'd0, q_desc.accumulator[15:0]};
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the beat while stalled
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> rtl/svm_implicit_operand_decoder_unit.sv
// Top level of the SVM implicit-operand decoder: front, queue and back.
// Depends on svm_iod_pkg, svm_iod_front, svm_iod_queue, svm_iod_back.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------
//   in      | in_valid / in_ready | in_data   (one instruction byte)
//   out     | out_valid/out_ready | out_data  (status, operand, size)
//
// One byte is taken per cycle while in_ready is high; non-final bytes only update
// the front state. A final byte is classified in its accept cycle and written into
// the queue; the back end then pops it and loads its result into the output
// register, which holds the beat until out_ready takes it.
// in_ready drops only when the two-entry queue is full (output stalled).
// Synchronous active-low reset clears the byte state, queue and output valid.
module svm_implicit_operand_decoder_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  svm_iod_pkg::in_beat_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output svm_iod_pkg::out_beat_t out_data
);
  import svm_iod_pkg::*;

  logic  q_push, q_full, q_pop, q_empty;
  desc_t push_desc, pop_desc;

  svm_iod_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_desc   (push_desc)
  );

  svm_iod_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_desc  (pop_desc)
  );

  svm_iod_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_desc    (pop_desc),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
